// ===== design/sbb_pkg.sv =====
package sbb_pkg;

    localparam int COL_W = 12;
    localparam int ROW_W = 12;
    localparam int FW_W  = 11;
    localparam int FH_W  = 12;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd600;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 12'd432;

    // Register select, taken from paddr[2].
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Pixel word: blue [7:0], green [15:8], red [23:16], alpha [31:24].
    typedef logic [31:0] t_pixel;

    // One horizontally filtered value on its way into the vertical pass.
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        t_pixel           hval;
        logic             emit_mix;
        logic             emit_h;
        logic             last;
    } t_hitem;

    // 1-2-1 weighting of the three colour channels; alpha comes from the middle word.
    function automatic t_pixel mix121(t_pixel a, t_pixel b, t_pixel c);
        logic [9:0] s;
        t_pixel     res;
        res = {b[31:24], 24'd0};
        for (int ch = 0; ch < 3; ch++) begin
            s = {2'b00, a[ch*8 +: 8]} + {1'b0, b[ch*8 +: 8], 1'b0} + {2'b00, c[ch*8 +: 8]};
            res[ch*8 +: 8] = s[9:2];
        end
        return res;
    endfunction

endpackage

// ===== design/sbb_vpass.sv =====
module sbb_vpass
    import sbb_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  t_hitem       i_item,
    input  logic         i_out_ready,
    output logic         o_valid,
    output t_pixel       o_word,
    output logic [9:0]   o_col,
    output logic [11:0]  o_row,
    output logic         o_last
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // Each entry holds the older row in [63:32] and the newer row in [31:0].
    logic [63:0]   mem [MAX_WIDTH];

    logic          r_b_valid;
    t_hitem        r_b;
    logic          r_b_idx;
    logic [63:0]   r_rd_data;
    logic          r_byp;
    logic [63:0]   r_byp_data;

    logic          r_o_valid;
    t_pixel        r_o_word;
    logic [9:0]    r_o_col;
    logic [11:0]   r_o_row;
    logic          r_o_last;

    logic          a_move;
    logic [CW-1:0] a_addr;
    logic [CW-1:0] b_addr;
    logic [63:0]   eff;
    logic [63:0]   new_entry;
    logic [1:0]    b_n;
    logic          out_free;
    logic          b_emit;
    logic          b_done;
    logic          first_is_mix;
    t_pixel        emit_word;
    logic [11:0]   emit_row;
    logic          emit_last;

    always_comb begin
        a_addr       = i_item.col[CW-1:0];
        b_addr       = r_b.col[CW-1:0];
        eff          = r_byp ? r_byp_data : r_rd_data;
        new_entry    = {eff[31:0], r_b.hval};
        b_n          = {1'b0, r_b.emit_mix} + {1'b0, r_b.emit_h};
        out_free     = !r_o_valid || i_out_ready;
        b_emit       = r_b_valid && ({1'b0, r_b_idx} < b_n) && out_free;
        b_done       = r_b_valid && ((b_n == 2'd0) || (b_emit && ({1'b0, r_b_idx} + 2'd1 == b_n)));
        o_ready      = !r_b_valid || b_done;
        a_move       = i_valid && o_ready;
        first_is_mix = !r_b_idx && r_b.emit_mix;
        emit_word    = first_is_mix ? mix121(eff[63:32], eff[31:0], r_b.hval) : r_b.hval;
        emit_row     = first_is_mix ? r_b.row - 12'd1 : r_b.row;
        emit_last    = r_b.last && ({1'b0, r_b_idx} + 2'd1 == b_n);
    end

    // A write to the column that is being read in the same cycle is forwarded.
    always_ff @(posedge i_clk) begin
        if (b_done) begin
            mem[b_addr] <= new_entry;
        end
        if (a_move) begin
            r_rd_data  <= mem[a_addr];
            r_byp_data <= new_entry;
            r_b        <= i_item;
        end
        if (b_emit) begin
            r_o_word <= emit_word;
            r_o_col  <= r_b.col[9:0];
            r_o_row  <= emit_row;
            r_o_last <= emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_idx   <= 1'b0;
            r_byp     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (a_move) begin
                r_b_valid <= 1'b1;
                r_b_idx   <= 1'b0;
                r_byp     <= b_done && (b_addr == a_addr);
            end else begin
                if (b_done) begin
                    r_b_valid <= 1'b0;
                end
                if (b_emit) begin
                    r_b_idx <= 1'b1;
                end
            end
            if (b_emit) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_o_valid;
    assign o_word  = r_o_word;
    assign o_col   = r_o_col;
    assign o_row   = r_o_row;
    assign o_last  = r_o_last;

endmodule

// ===== design/separable_binomial_blur.sv =====
// 3x3 binomial smoothing of a pixel stream, done as a horizontal and a vertical 1-2-1 pass.
// Pixels enter on the s_axis channel in raster order, one word per pixel. Results leave
// on m_axis, each carrying its own column and row, with tlast on the final result that a
// pixel causes; a pixel causes between zero and four results.
// Frame width and height are set over the APB port; a write restarts the frame at the next
// pixel. Write them only while the block is idle.
// A pixel's filtered values pass through the item register, the vertical stage and the result
// register before their results are valid on m_axis.
// The input takes a new pixel as the last filtered value of the previous one moves into the
// vertical stage; a pixel with two filtered values, or a busy or stalled vertical stage, holds
// it off until the values ahead have moved on.
// The vertical pass keeps two rows of filtered values in one memory of MAX_WIDTH entries,
// read and written once per filtered value.
// Reset clears the position counters, the frame size returns to 600 by 432 and all stages
// empty. The memory is not cleared: an entry is only used after it was written in the frame.
// When the receiver stalls, the result register holds, the vertical stage fills and the
// input then drops s_axis_tready; no word is lost.
module separable_binomial_blur
    import sbb_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // blue, green, red, alpha
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // out_blue, out_green, out_red, out_alpha, column, row, zero pad
    output logic        m_axis_tlast    // last_of_run
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [FW_W-1:0] r_fw;
    logic [FH_W-1:0] r_fh;
    logic [CW-1:0]   r_col;
    logic [11:0]     r_row;
    t_pixel          r_left;
    t_pixel          r_center;
    t_hitem          r_a_item [2];
    logic [1:0]      r_a_cnt;

    logic            cfg_wr;
    logic [12:0]     w_eff;
    logic [12:0]     wm1;
    logic [11:0]     hm1;
    logic [12:0]     x_ext;
    logic            row_end;
    logic            last_row;
    t_pixel          px;
    logic            has_first;
    logic            has_second;
    t_hitem          first_item;
    t_hitem          second_item;
    t_hitem          n_slot0;
    t_hitem          n_slot1;
    logic [1:0]      n_cnt;
    logic            in_fire;
    logic            a_move;
    logic            vp_ready;
    t_pixel          vp_word;
    logic [9:0]      vp_col;
    logic [11:0]     vp_row;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[2])
            REG_FRAME_HEIGHT: prdata = {20'd0, r_fh};
            default:          prdata = {21'd0, r_fw};
        endcase
    end

    // Width zero counts as one, and anything above the row store is clamped to it.
    always_comb begin
        if (r_fw == '0) begin
            w_eff = 13'd1;
        end else if ({2'b00, r_fw} > 13'(MAX_WIDTH)) begin
            w_eff = 13'(MAX_WIDTH);
        end else begin
            w_eff = {2'b00, r_fw};
        end
        wm1      = w_eff - 13'd1;
        hm1      = (r_fh == '0) ? 12'd0 : r_fh - 12'd1;
        x_ext    = 13'(r_col);
        row_end  = x_ext >= wm1;
        last_row = r_row >= hm1;
        px       = s_axis_tdata;
    end

    always_comb begin
        has_first  = (x_ext == 13'd0) || (x_ext >= 13'd2);
        has_second = (x_ext >= 13'd1) && row_end;

        first_item.col      = (x_ext == 13'd0) ? 12'd0 : 12'(r_col) - 12'd1;
        first_item.row      = r_row;
        first_item.hval     = (x_ext == 13'd0) ? px : mix121(r_left, r_center, px);
        first_item.emit_mix = r_row >= 12'd2;
        first_item.emit_h   = (r_row == 12'd0) || last_row;
        first_item.last     = !has_second;

        second_item          = first_item;
        second_item.col      = 12'(r_col);
        second_item.hval     = px;
        second_item.last     = 1'b1;

        if (has_first) begin
            n_slot0 = first_item;
            n_slot1 = second_item;
            n_cnt   = has_second ? 2'd2 : 2'd1;
        end else begin
            n_slot0 = second_item;
            n_slot1 = second_item;
            n_cnt   = has_second ? 2'd1 : 2'd0;
        end
    end

    assign a_move        = (r_a_cnt != 2'd0) && vp_ready;
    assign s_axis_tready = (r_a_cnt == 2'd0) || ((r_a_cnt == 2'd1) && a_move);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a_item[0] <= n_slot0;
            r_a_item[1] <= n_slot1;
        end else if (a_move) begin
            r_a_item[0] <= r_a_item[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw     <= FRAME_WIDTH_RST;
            r_fh     <= FRAME_HEIGHT_RST;
            r_col    <= '0;
            r_row    <= '0;
            r_left   <= '0;
            r_center <= '0;
            r_a_cnt  <= 2'd0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_FRAME_HEIGHT: r_fh <= pwdata[FH_W-1:0];
                    default:          r_fw <= pwdata[FW_W-1:0];
                endcase
                r_col <= '0;
                r_row <= '0;
            end else if (in_fire) begin
                if (row_end) begin
                    r_col <= '0;
                    r_row <= last_row ? 12'd0 : r_row + 12'd1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            if (in_fire) begin
                r_left   <= r_center;
                r_center <= px;
                r_a_cnt  <= n_cnt;
            end else if (a_move) begin
                r_a_cnt <= r_a_cnt - 2'd1;
            end
        end
    end

    sbb_vpass #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_vpass (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_a_cnt != 2'd0),
        .o_ready     (vp_ready),
        .i_item      (r_a_item[0]),
        .i_out_ready (m_axis_tready),
        .o_valid     (m_axis_tvalid),
        .o_word      (vp_word),
        .o_col       (vp_col),
        .o_row       (vp_row),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, vp_row, vp_col, vp_word};

endmodule

// ===== tb/separable_binomial_blur_tb.sv =====
`timescale 1ns / 1ps

module separable_binomial_blur_tb;
    import sbb_pkg::*;

    localparam int MAX_COLS      = 1024;
    localparam int RANDOM_ITEMS  = 246;
    localparam int SETTLE_CYCLES = 10;
    localparam int END_SLACK     = 20;
    localparam int CALM_TAIL     = 40;
    localparam int MAX_REPORTS   = 10;
    localparam int CYCLE_LIMIT   = 400000;

    typedef enum logic [1:0] {
        SK_PIXEL,
        SK_PAUSE,
        SK_WRITE
    } stim_kind_e;

    typedef enum logic [2:0] {
        DS_READY,
        DS_HOLD,
        DS_SETTLE,
        DS_SETUP,
        DS_ACCESS
    } drive_state_e;

    typedef struct {
        stim_kind_e  kind;
        t_pixel      pixel;
        logic        reg_sel;
        logic [31:0] value;
    } stim_t;

    typedef struct packed {
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [7:0]  alpha;
        logic [9:0]  column;
        logic [11:0] row;
        logic        last;
    } blur_result_t;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // blue, green, red, alpha
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;         // blue, green, red, alpha, column, row, zero pad
    logic        m_axis_tlast;         // last_of_run

    separable_binomial_blur #(
        .MAX_WIDTH(MAX_COLS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predicted state of the block.
    logic [FW_W-1:0] cfg_width  = FRAME_WIDTH_RST;
    logic [FH_W-1:0] cfg_height = FRAME_HEIGHT_RST;
    t_pixel          prev2_px   = '0;
    t_pixel          prev1_px   = '0;
    t_pixel          h_older [MAX_COLS];
    t_pixel          h_newer [MAX_COLS];
    int              col_cnt    = 0;
    int              row_cnt    = 0;
    int              step_results;

    blur_result_t    blur_expect [$];
    stim_t           pending_q [$];

    drive_state_e    drv_state   = DS_READY;
    int              settle_left = 0;
    int              gap_left    = 0;
    int              stall_left  = 0;
    bit              send_jitter = 1'b1;
    bit              sink_jitter = 1'b1;
    bit              calm_tail   = 1'b0;
    bit              stim_done   = 1'b0;
    int              fail_count  = 0;
    int              cycle_count = 0;

    function automatic t_pixel weigh121(t_pixel a, t_pixel b, t_pixel c);
        t_pixel      r;
        int unsigned s;
        r = b;
        for (int k = 0; k < 3; k++) begin
            s = a[8*k +: 8] + 2 * b[8*k +: 8] + c[8*k +: 8];
            r[8*k +: 8] = 8'(s >> 2);
        end
        return r;
    endfunction

    task automatic push_result(input t_pixel word, input int col, input int row);
        blur_result_t r;
        r.blue   = word[7:0];
        r.green  = word[15:8];
        r.red    = word[23:16];
        r.alpha  = word[31:24];
        r.column = 10'(col);
        r.row    = 12'(row);
        r.last   = 1'b0;
        blur_expect.push_back(r);
        step_results++;
    endtask

    // One horizontally filtered value enters the vertical pass.
    task automatic feed_vertical(input t_pixel hval, input int col, input int row,
                                 input int h);
        if (row >= 2)
            push_result(weigh121(h_older[col], h_newer[col], hval), col, row - 1);
        if (row == 0 || row >= h - 1)
            push_result(hval, col, row);
        h_older[col] = h_newer[col];
        h_newer[col] = hval;
    endtask

    task automatic predict_pixel(input t_pixel px);
        int w;
        int h;
        int x;
        int y;
        w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_COLS) ? MAX_COLS : int'(cfg_width));
        h = (cfg_height == 0) ? 1 : int'(cfg_height);
        x = col_cnt;
        y = row_cnt;
        step_results = 0;
        if (x == 0)
            feed_vertical(px, 0, y, h);
        else if (x >= 2)
            feed_vertical(weigh121(prev2_px, prev1_px, px), x - 1, y, h);
        if (x >= 1 && x >= w - 1)
            feed_vertical(px, x, y, h);
        prev2_px = prev1_px;
        prev1_px = px;
        if (x >= w - 1) begin
            col_cnt = 0;
            row_cnt = (y >= h - 1) ? 0 : y + 1;
        end else begin
            col_cnt = x + 1;
        end
        if (step_results > 0)
            blur_expect[blur_expect.size() - 1].last = 1'b1;
    endtask

    task automatic apply_register(input logic sel, input logic [31:0] value);
        if (sel == REG_FRAME_WIDTH)
            cfg_width = value[FW_W-1:0];
        else
            cfg_height = value[FH_W-1:0];
        col_cnt = 0;
        row_cnt = 0;
    endtask

    task automatic note_failure(input string msg);
        if (fail_count < MAX_REPORTS)
            $display("%s", msg);
        fail_count++;
    endtask

    task automatic add_pixel(input t_pixel px);
        stim_t s;
        s.kind    = SK_PIXEL;
        s.pixel   = px;
        s.reg_sel = REG_FRAME_WIDTH;
        s.value   = '0;
        pending_q.push_back(s);
    endtask

    task automatic add_write(input logic sel, input logic [31:0] value);
        stim_t s;
        s.kind    = SK_WRITE;
        s.pixel   = '0;
        s.reg_sel = sel;
        s.value   = value;
        pending_q.push_back(s);
    endtask

    task automatic add_pause();
        stim_t s;
        s.kind    = SK_PAUSE;
        s.pixel   = '0;
        s.reg_sel = REG_FRAME_WIDTH;
        s.value   = '0;
        pending_q.push_back(s);
    endtask

    function automatic t_pixel random_pixel();
        t_pixel p;
        p = $urandom;
        case ($urandom_range(0, 9))
            0: p = '0;
            1: p = '1;
            2: begin
                for (int k = 0; k < 4; k++)
                    p[8*k +: 8] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            end
            default: ;
        endcase
        return p;
    endfunction

    // Sender: pixels, drain pauses and register writes, taken in order from pending_q.
    always @(posedge i_clk) begin : drive_proc
        logic   nx_valid;
        t_pixel nx_data;
        logic   nx_psel;
        logic   nx_penable;
        stim_t  head;
        nx_valid   = s_axis_tvalid;
        nx_data    = s_axis_tdata;
        nx_psel    = psel;
        nx_penable = penable;
        if (i_rst_n) begin
            case (drv_state)
                DS_HOLD: begin
                    if (s_axis_tready) begin
                        predict_pixel(s_axis_tdata);
                        nx_valid  = 1'b0;
                        drv_state = DS_READY;
                    end
                end
                DS_SETUP: begin
                    nx_penable = 1'b1;
                    drv_state  = DS_ACCESS;
                end
                DS_ACCESS: begin
                    if (pready) begin
                        apply_register(pending_q[0].reg_sel, pending_q[0].value);
                        void'(pending_q.pop_front());
                        nx_psel    = 1'b0;
                        nx_penable = 1'b0;
                        drv_state  = DS_READY;
                    end
                end
                default: ;
            endcase

            if (drv_state == DS_SETTLE) begin
                if (settle_left > 0) begin
                    settle_left--;
                end else if (pending_q[0].kind == SK_PAUSE) begin
                    void'(pending_q.pop_front());
                    drv_state = DS_READY;
                end else begin
                    paddr     <= {pending_q[0].reg_sel, 2'b00};
                    pwdata    <= pending_q[0].value;
                    pwrite    <= 1'b1;
                    nx_psel   = 1'b1;
                    drv_state = DS_SETUP;
                end
            end else if (drv_state == DS_READY && pending_q.size() > 0) begin
                head = pending_q[0];
                if (head.kind == SK_PIXEL) begin
                    if (gap_left > 0) begin
                        gap_left--;
                    end else if (!calm_tail && send_jitter && $urandom_range(0, 5) == 0) begin
                        gap_left = $urandom_range(0, 6);
                    end else begin
                        void'(pending_q.pop_front());
                        nx_valid  = 1'b1;
                        nx_data   = head.pixel;
                        drv_state = DS_HOLD;
                    end
                end else if (blur_expect.size() == 0) begin
                    // A pixel that yields nothing may still be in flight.
                    settle_left = SETTLE_CYCLES;
                    drv_state   = DS_SETTLE;
                end
            end

            if (drv_state == DS_READY && pending_q.size() == 0)
                stim_done = 1'b1;
            if ($urandom_range(0, 31) == 0)
                send_jitter = !send_jitter;
            calm_tail = (pending_q.size() < CALM_TAIL);
        end
        s_axis_tvalid <= nx_valid;
        s_axis_tdata  <= nx_data;
        psel          <= nx_psel;
        penable       <= nx_penable;
    end

    // Receiver: checks each result word and applies back-pressure.
    always @(posedge i_clk) begin : sink_proc
        blur_result_t seen;
        blur_result_t want;
        logic         nx_ready;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen.blue   = m_axis_tdata[7:0];
                seen.green  = m_axis_tdata[15:8];
                seen.red    = m_axis_tdata[23:16];
                seen.alpha  = m_axis_tdata[31:24];
                seen.column = m_axis_tdata[41:32];
                seen.row    = m_axis_tdata[53:42];
                seen.last   = m_axis_tlast;
                if (blur_expect.size() == 0) begin
                    note_failure($sformatf(
                        "unexpected word: b=%h g=%h r=%h a=%h col=%0d row=%0d last=%b",
                        seen.blue, seen.green, seen.red, seen.alpha,
                        seen.column, seen.row, seen.last));
                end else begin
                    want = blur_expect.pop_front();
                    if (seen !== want)
                        note_failure($sformatf({
                            "mismatch: expected b=%h g=%h r=%h a=%h col=%0d row=%0d last=%b,",
                            " got b=%h g=%h r=%h a=%h col=%0d row=%0d last=%b"},
                            want.blue, want.green, want.red, want.alpha,
                            want.column, want.row, want.last,
                            seen.blue, seen.green, seen.red, seen.alpha,
                            seen.column, seen.row, seen.last));
                end
            end

            if (stall_left > 0) begin
                stall_left--;
                nx_ready = 1'b0;
            end else if (!calm_tail && sink_jitter && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 6);
                nx_ready   = 1'b0;
            end else begin
                nx_ready = 1'b1;
            end
            if ($urandom_range(0, 31) == 0)
                sink_jitter = !sink_jitter;
            m_axis_tready <= nx_ready;
        end
    end

    always @(posedge i_clk)
        cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int          random_pixels;
        int          n;
        int          pick;
        int          w_val;
        int          h_val;
        int          eff_w;
        int          eff_h;
        logic [31:0] w_reg;
        logic [31:0] h_reg;

        // Reset frame size: the start of a 600-wide frame.
        add_pixel(32'h0000_0000);
        add_pixel(32'hFFFF_FFFF);
        add_pixel(32'h8040_2010);
        add_pixel(32'h7FBF_DFEF);

        // Smallest frame with an interior pixel, with a drain pause part-way through.
        add_write(REG_FRAME_WIDTH, 32'd3);
        add_write(REG_FRAME_HEIGHT, 32'd3);
        for (int i = 0; i < 9; i++) begin
            add_pixel((i % 2 == 0) ? 32'hFFFF_FFFF : 32'h0000_0000);
            if (i == 3)
                add_pause();
        end

        // One column and one row: both passes leave the pixel as it is.
        add_write(REG_FRAME_WIDTH, 32'd1);
        add_write(REG_FRAME_HEIGHT, 32'd1);
        add_pixel(32'h55AA_55AA);
        add_pixel(32'hAA55_AA55);
        add_pixel(32'h0102_0304);

        // Zero sizes count as one.
        add_write(REG_FRAME_WIDTH, 32'd0);
        add_write(REG_FRAME_HEIGHT, 32'd0);
        add_pixel(32'hFF00_FF00);
        add_pixel(32'h00FF_00FF);

        add_write(REG_FRAME_WIDTH, 32'd2);
        add_write(REG_FRAME_HEIGHT, 32'd2);
        for (int i = 0; i < 4; i++)
            add_pixel(random_pixel());

        // Oversize width is clamped to the row store depth.
        add_write(REG_FRAME_WIDTH, 32'd2047);
        add_write(REG_FRAME_HEIGHT, 32'd4095);
        add_pixel(32'hFFFF_FFFF);
        add_pixel(32'h0000_0000);

        w_reg = 32'd2047;
        h_reg = 32'd4095;
        random_pixels = 0;
        while (random_pixels < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                w_val = 0;
            else if (pick == 1)
                w_val = 1024;
            else if (pick == 2)
                w_val = $urandom_range(1025, 2047);
            else if (pick == 3)
                w_val = $urandom_range(13, 1023);
            else
                w_val = $urandom_range(1, 12);
            pick = $urandom_range(0, 19);
            if (pick == 0)
                h_val = 0;
            else if (pick == 1)
                h_val = 4095;
            else if (pick == 2)
                h_val = $urandom_range(9, 4094);
            else
                h_val = $urandom_range(1, 8);

            // Unused upper bits of the write word carry junk.
            pick = $urandom_range(0, 3);
            if (pick != 1) begin
                w_reg = ($urandom & ~32'h7FF) | w_val;
                add_write(REG_FRAME_WIDTH, w_reg);
            end
            if (pick != 0) begin
                h_reg = ($urandom & ~32'hFFF) | h_val;
                add_write(REG_FRAME_HEIGHT, h_reg);
            end

            eff_w = (w_reg[10:0] == 0) ? 1 : ((w_reg[10:0] > MAX_COLS) ? MAX_COLS
                                                                        : int'(w_reg[10:0]));
            eff_h = (h_reg[11:0] == 0) ? 1 : int'(h_reg[11:0]);
            // Mostly whole frames; otherwise a frame broken off part-way.
            if (eff_w * eff_h <= 96 && $urandom_range(0, 3) != 0)
                n = eff_w * eff_h * $urandom_range(1, 2);
            else
                n = $urandom_range(3, 30);
            if (n > RANDOM_ITEMS - random_pixels)
                n = RANDOM_ITEMS - random_pixels;

            for (int i = 0; i < n; i++) begin
                add_pixel(random_pixel());
                if ($urandom_range(0, 199) == 0)
                    add_pause();
            end
            random_pixels += n;
        end
        add_pause();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (stim_done);
        repeat (END_SLACK) @(posedge i_clk);
        if (blur_expect.size() != 0)
            note_failure($sformatf("%0d expected words never arrived", blur_expect.size()));

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/sbb_pkg.sv
design/sbb_vpass.sv
design/separable_binomial_blur.sv
tb/separable_binomial_blur_tb.sv
